FILE: rtl/blp_pkg.sv
// Shared types and constants for the band-limited pulse oscillator.
package blp_pkg;

    // Table geometry and number formats
    localparam int TABLE_SIZE      = 1024;
    localparam int TABLE_AW        = $clog2(TABLE_SIZE);
    localparam int PHASE_FRAC_BITS = 16;
    localparam int PHASE_W         = TABLE_AW + PHASE_FRAC_BITS;
    localparam int SAMPLE_BITS     = 16;
    localparam int TW              = 16;
    localparam int AMP_W           = 16;
    localparam int HARM_W          = 9;

    // Datapath widths
    localparam int M_W    = HARM_W + 1;
    localparam int D_W    = TW + M_W + 1;
    localparam int E_W    = D_W + 1;
    localparam int NUM_W  = AMP_W + E_W;
    localparam int DEN_W  = D_W + M_W;
    localparam int ACC_W  = NUM_W + 1;
    localparam int MIER_W = AMP_W;
    localparam int Q_W    = SAMPLE_BITS + 1;
    localparam int DV_W   = DEN_W + SAMPLE_BITS;
    localparam int CNT_W  = $clog2(Q_W);

    // Stream packing
    localparam int IDX_LSB   = 0;
    localparam int VAL_LSB   = IDX_LSB + TABLE_AW;
    localparam int AMP_LSB   = VAL_LSB + TW;
    localparam int INC_LSB   = AMP_LSB + AMP_W;
    localparam int HARM_LSB  = INC_LSB + PHASE_W;
    localparam int IN_BITS   = HARM_LSB + HARM_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

    localparam logic [Q_W-1:0] SAMPLE_POS_MAX = Q_W'((2 ** (SAMPLE_BITS - 1)) - 1);
    localparam logic [Q_W-1:0] SAMPLE_NEG_MAG = Q_W'(2 ** (SAMPLE_BITS - 1));

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_GEN   = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_MUL,
        ST_RDN0,
        ST_RDN1,
        ST_DIV,
        ST_DONE
    } t_state;

    // Which product the shift-add unit is forming
    typedef enum logic [2:0] {
        STEP_FRAC,
        STEP_NIDX,
        STEP_DA,
        STEP_DB,
        STEP_E,
        STEP_NUM,
        STEP_DEN
    } t_step;

endpackage

FILE: rtl/blp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module blp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/band_limited_pulse_oscillator_core.sv
// Band-limited pulse oscillator: sine table, phase accumulator and serial arithmetic.
// A table write request is taken while idle and the block is ready again the next cycle.
// A generate request runs through the table reads, the one-bit-per-cycle shift-add multiplier
// (seven products) and, unless the denominator is zero, the 17-step divider before a result is ready.
// One request at a time: a new request is not taken until the result is handed to the output register.
// Synchronous active-low reset clears the phase to zero; table contents are not cleared.
module band_limited_pulse_oscillator_core
    import blp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // table_index, table_value, amplitude, phase_increment, harmonics, zero pad
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // opcode
    input  logic                  i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // sample
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // saturated
    output logic                  o_m_axis_tuser
);

    t_state r_state, n_state;
    t_step  r_step,  n_step;

    logic [PHASE_W-1:0]     r_phase, n_phase;
    logic [PHASE_W-1:0]     r_inc,   n_inc;
    logic [AMP_W-1:0]       r_amp,   n_amp;
    logic [M_W-1:0]         r_m,     n_m;
    logic [TW-1:0]          r_tj,    n_tj;
    logic [TW-1:0]          r_tk,    n_tk;
    logic [TW-1:0]          r_tn,    n_tn;
    logic [M_W-1:0]         r_s,     n_s;
    logic [TABLE_AW-1:0]    r_ni,    n_ni;
    logic [D_W-1:0]         r_d,     n_d;
    logic [ACC_W-1:0]       r_acc,   n_acc;
    logic [ACC_W-1:0]       r_cand,  n_cand;
    logic [MIER_W-1:0]      r_mier,  n_mier;
    logic                   r_neg,   n_neg;
    logic [NUM_W-1:0]       r_rem,   n_rem;
    logic [DV_W-1:0]        r_dv,    n_dv;
    logic [Q_W-1:0]         r_q,     n_q;
    logic [CNT_W-1:0]       r_cnt,   n_cnt;
    logic [SAMPLE_BITS-1:0] r_res,   n_res;
    logic                   r_sat,   n_sat;
    logic                   r_out_valid, n_out_valid;
    logic [SAMPLE_BITS-1:0] r_out_sample, n_out_sample;
    logic                   r_out_sat, n_out_sat;

    logic                   w_in_acc;
    logic                   w_ram_we;
    logic [TABLE_AW-1:0]    w_raddr;
    logic [TW-1:0]          w_rdata;
    logic [TABLE_AW-1:0]    w_j;
    logic [TABLE_AW-1:0]    w_k;
    logic [HARM_W-1:0]      w_harm;
    logic [HARM_W-1:0]      w_n_eff;
    logic [ACC_W-1:0]       w_sum;
    logic [TW:0]            w_tdiff;
    logic [ACC_W-1:0]       w_e_mag;
    logic [AMP_W-1:0]       w_amp_mag;
    logic [D_W-1:0]         w_d_mag;
    logic [DV_W:0]          w_div_diff;
    logic                   w_qbit;
    logic [Q_W-1:0]         w_q_fin;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_ram_we        = w_in_acc && (i_s_axis_tuser == OP_WRITE);

    assign w_j     = r_phase[PHASE_W-1 -: TABLE_AW];
    assign w_k     = w_j + TABLE_AW'(1);
    assign w_harm  = i_s_axis_tdata[HARM_LSB +: HARM_W];
    // Zero harmonics behaves as one harmonic.
    assign w_n_eff = (w_harm == '0) ? HARM_W'(1) : w_harm;

    assign w_sum     = r_acc + r_cand;
    assign w_tdiff   = {r_tk[TW-1], r_tk} - {r_tj[TW-1], r_tj};
    assign w_e_mag   = r_acc[ACC_W-1] ? (~r_acc + ACC_W'(1)) : r_acc;
    assign w_amp_mag = r_amp[AMP_W-1] ? (~r_amp + AMP_W'(1)) : r_amp;
    assign w_d_mag   = r_d[D_W-1] ? (~r_d + D_W'(1)) : r_d;

    assign w_div_diff = {1'b0, DV_W'(r_rem)} - {1'b0, r_dv};
    assign w_qbit     = ~w_div_diff[DV_W];
    assign w_q_fin    = {r_q[Q_W-2:0], w_qbit};

    always_comb begin
        unique case (r_state)
            ST_RD0:  w_raddr = w_j;
            ST_RD1:  w_raddr = w_k;
            default: w_raddr = r_ni;
        endcase
    end

    blp_ram #(
        .WIDTH (TW),
        .DEPTH (TABLE_SIZE)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (i_s_axis_tdata[IDX_LSB +: TABLE_AW]),
        .i_wdata (i_s_axis_tdata[VAL_LSB +: TW]),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step       <= n_step;
        r_inc        <= n_inc;
        r_amp        <= n_amp;
        r_m          <= n_m;
        r_tj         <= n_tj;
        r_tk         <= n_tk;
        r_tn         <= n_tn;
        r_s          <= n_s;
        r_ni         <= n_ni;
        r_d          <= n_d;
        r_acc        <= n_acc;
        r_cand       <= n_cand;
        r_mier       <= n_mier;
        r_neg        <= n_neg;
        r_rem        <= n_rem;
        r_dv         <= n_dv;
        r_q          <= n_q;
        r_cnt        <= n_cnt;
        r_res        <= n_res;
        r_sat        <= n_sat;
        r_out_sample <= n_out_sample;
        r_out_sat    <= n_out_sat;
    end

    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        n_phase      = r_phase;
        n_inc        = r_inc;
        n_amp        = r_amp;
        n_m          = r_m;
        n_tj         = r_tj;
        n_tk         = r_tk;
        n_tn         = r_tn;
        n_s          = r_s;
        n_ni         = r_ni;
        n_d          = r_d;
        n_acc        = r_acc;
        n_cand       = r_cand;
        n_mier       = r_mier;
        n_neg        = r_neg;
        n_rem        = r_rem;
        n_dv         = r_dv;
        n_q          = r_q;
        n_cnt        = r_cnt;
        n_res        = r_res;
        n_sat        = r_sat;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_sample = r_out_sample;
        n_out_sat    = r_out_sat;

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc && (i_s_axis_tuser == OP_GEN)) begin
                    n_amp   = i_s_axis_tdata[AMP_LSB +: AMP_W];
                    n_inc   = i_s_axis_tdata[INC_LSB +: PHASE_W];
                    n_m     = {w_n_eff, 1'b1};
                    n_state = ST_RD0;
                end
            end

            ST_RD0: n_state = ST_RD1;

            ST_RD1: begin
                n_tj    = w_rdata;
                n_state = ST_RD2;
            end

            ST_RD2: begin
                n_tk    = w_rdata;
                n_acc   = '0;
                n_cand  = ACC_W'(r_phase[PHASE_FRAC_BITS-1:0]);
                n_mier  = MIER_W'(r_m);
                n_step  = STEP_FRAC;
                n_state = ST_MUL;
            end

            ST_MUL: begin
                if (r_mier != '0) begin
                    n_acc  = r_mier[0] ? w_sum : r_acc;
                    n_cand = {r_cand[ACC_W-2:0], 1'b0};
                    n_mier = r_mier >> 1;
                end else begin
                    unique case (r_step)
                        STEP_FRAC: begin
                            n_s    = r_acc[PHASE_FRAC_BITS +: M_W];
                            n_acc  = '0;
                            n_cand = ACC_W'(r_phase);
                            n_mier = MIER_W'(r_m);
                            n_step = STEP_NIDX;
                        end
                        STEP_NIDX: begin
                            n_ni    = r_acc[PHASE_FRAC_BITS +: TABLE_AW];
                            n_state = ST_RDN0;
                        end
                        STEP_DA: begin
                            n_cand = {{(ACC_W-TW-1){w_tdiff[TW]}}, w_tdiff};
                            n_mier = MIER_W'(r_s);
                            n_step = STEP_DB;
                        end
                        STEP_DB: begin
                            // A zero denominator passes the amplitude straight through.
                            if (r_acc == '0) begin
                                n_res   = r_amp;
                                n_sat   = 1'b0;
                                n_state = ST_DONE;
                            end else begin
                                n_d    = r_acc[D_W-1:0];
                                n_acc  = ~r_acc + ACC_W'(1);
                                n_cand = {{(ACC_W-TW){r_tn[TW-1]}}, r_tn};
                                n_mier = MIER_W'(r_m);
                                n_step = STEP_E;
                            end
                        end
                        STEP_E: begin
                            n_neg  = r_amp[AMP_W-1] ^ r_acc[ACC_W-1] ^ r_d[D_W-1];
                            n_acc  = '0;
                            n_cand = w_e_mag;
                            n_mier = w_amp_mag;
                            n_step = STEP_NUM;
                        end
                        STEP_NUM: begin
                            n_rem  = r_acc[NUM_W-1:0];
                            n_acc  = '0;
                            n_cand = ACC_W'(w_d_mag);
                            n_mier = MIER_W'({r_m[M_W-1:1], 1'b0});
                            n_step = STEP_DEN;
                        end
                        STEP_DEN: begin
                            n_dv    = {r_acc[DEN_W-1:0], {SAMPLE_BITS{1'b0}}};
                            n_q     = '0;
                            n_cnt   = CNT_W'(Q_W - 1);
                            n_state = ST_DIV;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end

            ST_RDN0: n_state = ST_RDN1;

            ST_RDN1: begin
                n_tn    = w_rdata;
                n_acc   = '0;
                n_cand  = {{(ACC_W-TW){r_tj[TW-1]}}, r_tj};
                n_mier  = MIER_W'(r_m);
                n_step  = STEP_DA;
                n_state = ST_MUL;
            end

            ST_DIV: begin
                // Restoring division; the top quotient bit only flags overflow.
                if (w_qbit) begin
                    n_rem = w_div_diff[NUM_W-1:0];
                end
                n_q  = w_q_fin;
                n_dv = r_dv >> 1;
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    if (!r_neg) begin
                        if (w_q_fin > SAMPLE_POS_MAX) begin
                            n_res = SAMPLE_POS_MAX[SAMPLE_BITS-1:0];
                            n_sat = 1'b1;
                        end else begin
                            n_res = w_q_fin[SAMPLE_BITS-1:0];
                            n_sat = 1'b0;
                        end
                    end else begin
                        if (w_q_fin > SAMPLE_NEG_MAG) begin
                            n_res = SAMPLE_NEG_MAG[SAMPLE_BITS-1:0];
                            n_sat = 1'b1;
                        end else begin
                            n_res = ~w_q_fin[SAMPLE_BITS-1:0] + SAMPLE_BITS'(1);
                            n_sat = 1'b0;
                        end
                    end
                    n_state = ST_DONE;
                end
            end

            ST_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_sample = r_res;
                    n_out_sat    = r_sat;
                    n_phase      = r_phase + r_inc;
                    n_state      = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_DATA_W'(r_out_sample);
    assign o_m_axis_tuser  = r_out_sat;

endmodule
